>>> sv/rgb_to_hsv_converter_defines.svh
// Assertion macros used by the RGB to HSV converter checker.
// Depends on nothing; the using module must provide clk_i and rst_ni.

`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rhc_pkg.sv
// Types and constants for the RGB to HSV converter.
// Depends on nothing; used by the converter and its checker.

package rhc_pkg;

  localparam int unsigned CHANNEL_BITS  = 8;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned HUE_DIV_BITS  = CHANNEL_BITS + 3;
  localparam int unsigned SAT_NUM_BITS  = CHANNEL_BITS + FRACTION_BITS;

  typedef enum logic [1:0] {
    WIN_RED   = 2'd0,
    WIN_GREEN = 2'd1,
    WIN_BLUE  = 2'd2
  } rhc_win_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rhc_pixel_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  brightness;
  } rhc_hsv_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] d;
    rhc_win_e                win;
    logic                    neg;
    logic [CHANNEL_BITS-1:0] mag;
  } rhc_ext_t;

  typedef struct packed {
    logic [HUE_DIV_BITS-1:0]  hrem;
    logic [HUE_DIV_BITS-1:0]  hdiv;
    logic [FRACTION_BITS-1:0] hq;
    logic [CHANNEL_BITS-1:0]  srem;
    logic [CHANNEL_BITS-1:0]  sdiv;
    logic [FRACTION_BITS-1:0] snum_lo;
    logic [FRACTION_BITS-1:0] sq;
    logic [CHANNEL_BITS-1:0]  mx;
  } rhc_div_t;

endpackage

>>> sv/rgb_to_hsv_converter.sv
// Pipelined RGB to HSV pixel converter.
// Depends on rhc_pkg for the payload structs, stage structs and widths.

// The converter accepts one pixel per clock while the output register is empty
// or its result is taken, and presents each result through FRACTION_BITS + 3
// register stages: one input register, one stage that finds the largest and
// smallest channels, one that forms the hue angle and both divisors, and then
// one restoring division step per quotient bit, with hue and saturation
// divided side by side. The last division stage is the output register. When
// a result is not taken, the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated.
module rgb_to_hsv_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rhc_pkg::rhc_pixel_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rhc_pkg::rhc_hsv_t  out_data_o
);
  import rhc_pkg::*;

  localparam int unsigned NumStages = FRACTION_BITS + 3;
  localparam int unsigned CW        = CHANNEL_BITS;
  localparam int unsigned FW        = FRACTION_BITS;
  localparam int unsigned HW        = HUE_DIV_BITS;
  localparam int unsigned SW        = SAT_NUM_BITS;

  logic                 adv;
  logic [NumStages-1:0] valid_q;
  rhc_pixel_t           pix_q;
  rhc_ext_t             ext_d, ext_q;
  rhc_div_t             div_d [FW+1];
  rhc_div_t             div_q [FW+1];

  assign adv        = out_ready_i || !valid_q[NumStages-1];
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q <= in_data_i;
      ext_q <= ext_d;
    end
  end

  // Stage one: extremes, winning channel and the signed channel difference.
  logic [CW-1:0] r, g, b, mn, op_a, op_b;
  logic          r_ge_g, r_ge_b, g_ge_b;

  always_comb begin
    r      = pix_q.red;
    g      = pix_q.green;
    b      = pix_q.blue;
    r_ge_g = r >= g;
    r_ge_b = r >= b;
    g_ge_b = g >= b;
    ext_d  = '0;
    if (r_ge_g && r_ge_b) begin
      ext_d.win = WIN_RED;
      ext_d.mx  = r;
    end else if (g_ge_b) begin
      ext_d.win = WIN_GREEN;
      ext_d.mx  = g;
    end else begin
      ext_d.win = WIN_BLUE;
      ext_d.mx  = b;
    end
    if (!r_ge_g && !r_ge_b) begin
      mn = r;
    end else if (!g_ge_b) begin
      mn = g;
    end else begin
      mn = b;
    end
    ext_d.d = ext_d.mx - mn;
    case (ext_d.win)
      WIN_RED: begin
        op_a = g;
        op_b = b;
      end
      WIN_GREEN: begin
        op_a = b;
        op_b = r;
      end
      WIN_BLUE: begin
        op_a = r;
        op_b = g;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    ext_d.neg = op_a < op_b;
    ext_d.mag = ext_d.neg ? (op_b - op_a) : (op_a - op_b);
  end

  // Stage two: hue angle, both divisors and the saturation numerator.
  logic [HW-1:0] d_w, d2, d4, d6, off, mag_w;
  logic [SW-1:0] snum;

  always_comb begin
    d_w   = HW'(ext_q.d);
    d2    = d_w << 1;
    d4    = d_w << 2;
    d6    = d4 + d2;
    mag_w = HW'(ext_q.mag);
    case (ext_q.win)
      WIN_RED:   off = ext_q.neg ? d6 : '0;
      WIN_GREEN: off = d2;
      WIN_BLUE:  off = d4;
      default:   off = '0;
    endcase
    snum              = (SW'(ext_q.d) << FW) - SW'(ext_q.d);
    div_d[0]          = '0;
    div_d[0].hrem     = ext_q.neg ? (off - mag_w) : (off + mag_w);
    div_d[0].hdiv     = (ext_q.d == '0) ? HW'(6) : d6;
    div_d[0].srem     = snum[SW-1:FW];
    div_d[0].snum_lo  = snum[FW-1:0];
    div_d[0].sdiv     = (ext_q.mx == '0) ? CW'(1) : ext_q.mx;
    div_d[0].mx       = ext_q.mx;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_d[0];
    end
  end

  // One restoring division step per stage for each quotient.
  for (genvar k = 0; k < FW; k++) begin : g_div
    logic [HW:0] h2, hsub;
    logic [CW:0] s2, ssub;
    logic        hge, sge;

    always_comb begin
      h2   = {div_q[k].hrem, 1'b0};
      hsub = h2 - {1'b0, div_q[k].hdiv};
      hge  = h2 >= {1'b0, div_q[k].hdiv};
      s2   = {div_q[k].srem, div_q[k].snum_lo[FW-1]};
      ssub = s2 - {1'b0, div_q[k].sdiv};
      sge  = s2 >= {1'b0, div_q[k].sdiv};

      div_d[k+1]         = div_q[k];
      div_d[k+1].hrem    = hge ? hsub[HW-1:0] : h2[HW-1:0];
      div_d[k+1].hq      = {div_q[k].hq[FW-2:0], hge};
      div_d[k+1].srem    = sge ? ssub[CW-1:0] : s2[CW-1:0];
      div_d[k+1].snum_lo = {div_q[k].snum_lo[FW-2:0], 1'b0};
      div_d[k+1].sq      = {div_q[k].sq[FW-2:0], sge};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1] <= div_d[k+1];
      end
    end
  end

  assign out_valid_o           = valid_q[NumStages-1];
  assign out_data_o.hue        = div_q[FW].hq;
  assign out_data_o.saturation = div_q[FW].sq;
  assign out_data_o.brightness = div_q[FW].mx;

endmodule

>>> sv/rhc_checker.sv
// Port-level checker for the RGB to HSV converter, bound to its top level.
// Depends on rhc_pkg and the assertion macros in rgb_to_hsv_converter_defines.svh.

`include "rgb_to_hsv_converter_defines.svh"

module rhc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rhc_pkg::rhc_pixel_t in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rhc_pkg::rhc_hsv_t   out_data_o
);
  import rhc_pkg::*;

  logic in_seen;
  assign in_seen = in_valid_i && (in_data_i.red == in_data_i.red);

  `RHC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "Output transaction changed while stalled.")
  `RHC_ASSERT_SAME(a_stall_backpressure, out_valid_o && !out_ready_i, !in_ready_o, "Input taken while the output is stalled.")
  `RHC_ASSERT_SAME(a_black_pixel, out_valid_o && out_data_o.brightness == '0, out_data_o.saturation == '0 && out_data_o.hue == '0, "Black pixel gave nonzero hue or saturation.")
  `RHC_ASSERT_SAME(a_grey_pixel, out_valid_o && out_data_o.saturation == '0, out_data_o.hue == '0, "Grey pixel gave nonzero hue.")
  `RHC_ASSERT_SAME(a_ready_when_empty, !out_valid_o && in_seen, in_ready_o, "Input refused with an empty output stage.")

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);
